// ----- rtl/fwca_pkg.sv -----
// Shared types and constants of the flagged weighted cell averager.
package fwca_pkg;

    localparam int MAX_ANTS_DEF = 16;
    localparam int POLS_DEF     = 2;
    localparam int CHANS_DEF    = 16;
    localparam int ROWS_DEF     = 136;

    localparam int ROWC_W = 12;   // row arithmetic, enough for 2080 rows
    localparam int IN_D_W  = 184;
    localparam int IN_U_W  = 3;
    localparam int OUT_D_W = 168;
    localparam int OUT_U_W = 3;

    localparam logic [1:0] FUNC_CLR = 2'd0;
    localparam logic [1:0] FUNC_ACC = 2'd1;
    localparam logic [1:0] FUNC_RD  = 2'd2;

    localparam logic [1:0] MODE_ALL  = 2'd0;
    localparam logic [1:0] MODE_ANT  = 2'd1;
    localparam logic [1:0] MODE_BASE = 2'd2;
    localparam logic [1:0] MODE_AVG  = 2'd3;

    localparam logic [1:0] REG_ROW_MODE  = 2'd0;
    localparam logic [1:0] REG_NUM_ANTS  = 2'd1;
    localparam logic [1:0] REG_NUM_CHANS = 2'd2;
    localparam logic [1:0] REG_CPB       = 2'd3;

    typedef enum logic [1:0] {
        RES_OK,
        RES_ERR,
        RES_READ
    } res_kind_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_DECODE,
        ST_BIN,
        ST_ACC_RD,
        ST_ACC_MUL,
        ST_ACC_WR,
        ST_RD_RD,
        ST_RD_CAP,
        ST_DIV_INIT,
        ST_DIV,
        ST_RESP
    } fwca_state_t;

    typedef struct packed {
        logic               flag;
        logic [39:0]        wsum;
        logic [3:0][63:0]   sum;   // re, im, err, snr from index 0
    } fwca_cell_t;

    typedef struct packed {
        logic      in_ready;
        logic      clr_start;
        logic      clr_step;
        logic      seen_mark;
        logic      bin_init;
        logic      bin_step;
        logic      row_sel;
        logic      rd_read;
        logic      cap;
        logic      wr_en;
        logic      div_init;
        logic      div_step;
        logic      res_load;
        res_kind_t res_kind;
    } fwca_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       acc_reject;
        logic       rd_reject;
        logic       two_rows;
        logic       bin_more;
        logic       bin_drop;
        logic       clr_last;
        logic       div_last;
        logic       out_hold;
    } fwca_sts_t;

endpackage

// ----- rtl/fwca_ram.sv -----
// Generic single write port RAM with registered read.
module fwca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/fwca_ctrl.sv -----
// Sequencer: steps each item through decode, then a clearing sweep, binning and cell update, or divide.
module fwca_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  fwca_pkg::fwca_sts_t sts,
    output fwca_pkg::fwca_cmd_t cmd
);
    import fwca_pkg::*;

    fwca_state_t state_reg, state_next;
    logic        row_sel_reg, row_sel_next;
    logic        boot_reg, boot_next;
    res_kind_t   kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            row_sel_reg <= 1'b0;
            boot_reg    <= 1'b1;
            kind_reg    <= RES_OK;
        end
        else
        begin
            state_reg   <= state_next;
            row_sel_reg <= row_sel_next;
            boot_reg    <= boot_next;
            kind_reg    <= kind_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        row_sel_next = row_sel_reg;
        boot_next    = boot_reg;
        kind_next    = kind_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                if (sts.clr_last)
                begin
                    boot_next  = 1'b0;
                    kind_next  = RES_OK;
                    state_next = boot_reg ? ST_IDLE : ST_RESP;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (sts.func)
                    FUNC_CLR: state_next = ST_CLR;
                    FUNC_ACC:
                    begin
                        if (sts.acc_reject)
                        begin
                            kind_next  = RES_ERR;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_BIN;
                        end
                    end
                    FUNC_RD:
                    begin
                        if (sts.rd_reject)
                        begin
                            kind_next  = RES_ERR;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_RD_RD;
                        end
                    end
                    default:
                    begin
                        kind_next  = RES_ERR;
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_BIN:
            begin
                if (!sts.bin_more)
                begin
                    row_sel_next = 1'b0;
                    if (sts.bin_drop)
                    begin
                        kind_next  = RES_OK;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_ACC_RD;
                    end
                end
            end
            ST_ACC_RD:  state_next = ST_ACC_MUL;
            ST_ACC_MUL: state_next = ST_ACC_WR;
            ST_ACC_WR:
            begin
                if (sts.two_rows && !row_sel_reg)
                begin
                    row_sel_next = 1'b1;
                    state_next   = ST_ACC_RD;
                end
                else
                begin
                    kind_next  = RES_OK;
                    state_next = ST_RESP;
                end
            end
            ST_RD_RD:    state_next = ST_RD_CAP;
            ST_RD_CAP:   state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    kind_next  = RES_READ;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!sts.out_hold)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.row_sel  = row_sel_reg;
        cmd.res_kind = kind_reg;
        unique case (state_reg)
            ST_CLR:  cmd.clr_step = 1'b1;
            ST_IDLE: cmd.in_ready = 1'b1;
            ST_DECODE:
            begin
                if (sts.func == FUNC_CLR)
                begin
                    cmd.clr_start = 1'b1;
                end
                if (sts.func == FUNC_ACC && !sts.acc_reject)
                begin
                    cmd.seen_mark = 1'b1;
                    cmd.bin_init  = 1'b1;
                end
            end
            ST_BIN:      cmd.bin_step = sts.bin_more;
            ST_ACC_RD:   cmd.rd_read  = 1'b0;
            ST_ACC_MUL:  cmd.cap      = 1'b1;
            ST_ACC_WR:   cmd.wr_en    = 1'b1;
            ST_RD_RD:    cmd.rd_read  = 1'b1;
            ST_RD_CAP:
            begin
                cmd.rd_read = 1'b1;
                cmd.cap     = 1'b1;
            end
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_RESP:     cmd.res_load = !sts.out_hold;
            default:     cmd.in_ready = 1'b0;
        endcase
    end
endmodule

// ----- rtl/fwca_dp.sv -----
// Datapath: config, item decode, cell memory, update arithmetic, divider, output.
module fwca_dp #(
    parameter int MAX_ANTS = fwca_pkg::MAX_ANTS_DEF,
    parameter int POLS     = fwca_pkg::POLS_DEF,
    parameter int CHANS    = fwca_pkg::CHANS_DEF,
    parameter int ROWS     = fwca_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [4:0]                    cfg_wdata,
    input  logic                          s_tvalid,
    input  logic [fwca_pkg::IN_D_W-1:0]   s_tdata,
    input  logic [fwca_pkg::IN_U_W-1:0]   s_tuser,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [fwca_pkg::OUT_D_W-1:0]  m_tdata,
    output logic [fwca_pkg::OUT_U_W-1:0]  m_tuser,
    input  fwca_pkg::fwca_cmd_t           cmd,
    output fwca_pkg::fwca_sts_t           sts
);
    import fwca_pkg::*;

    localparam int CELLS  = ROWS * POLS * CHANS;
    localparam int CA_W   = CELLS > 1 ? $clog2(CELLS) : 1;
    localparam int ROW_W  = ROWS > 1 ? $clog2(ROWS) : 1;
    localparam int CELL_W = $bits(fwca_cell_t);

    // configuration
    logic [1:0] row_mode_reg;
    logic [4:0] num_ants_reg, num_chans_reg, cpb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_mode_reg  <= MODE_ANT;
            num_ants_reg  <= 5'd16;
            num_chans_reg <= 5'd16;
            cpb_reg       <= 5'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_ROW_MODE:  row_mode_reg  <= cfg_wdata[1:0];
                REG_NUM_ANTS:  num_ants_reg  <= cfg_wdata;
                REG_NUM_CHANS: num_chans_reg <= cfg_wdata;
                REG_CPB:       cpb_reg       <= cfg_wdata;
                default:       row_mode_reg  <= row_mode_reg;
            endcase
        end
    end

    // item capture
    logic [1:0]         func_reg;
    logic [3:0]         a1_reg;
    logic [4:0]         a2_reg;
    logic [7:0]         rrow_reg;
    logic               pol_reg;
    logic [3:0]         ch_reg;
    logic               flg_reg;
    logic [31:0]        w_reg;
    logic [31:0]        val_reg [4];
    logic               accept;

    assign accept = cmd.in_ready && s_tvalid;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= s_tuser[1:0];
            flg_reg    <= s_tuser[2];
            a1_reg     <= s_tdata[3:0];
            a2_reg     <= s_tdata[8:4];
            rrow_reg   <= s_tdata[16:9];
            pol_reg    <= s_tdata[17];
            ch_reg     <= s_tdata[21:18];
            w_reg      <= s_tdata[53:22];
            val_reg[0] <= s_tdata[85:54];
            val_reg[1] <= s_tdata[117:86];
            val_reg[2] <= s_tdata[149:118];
            val_reg[3] <= s_tdata[181:150];
        end
    end

    // decode
    logic [4:0]        na, nc, cpb0, cpb;
    logic signed [7:0] a1s, a2s, nas;
    logic [7:0]        tri_n;
    logic [ROWC_W-1:0] row0, row1, arow;
    logic              pol_bad, ant_bad, two_rows;

    always_comb
    begin
        na   = (num_ants_reg == 5'd0) ? 5'd1 :
               (32'(num_ants_reg) > MAX_ANTS ? 5'(MAX_ANTS) : num_ants_reg);
        nc   = (num_chans_reg == 5'd0) ? 5'd1 :
               (32'(num_chans_reg) > CHANS ? 5'(CHANS) : num_chans_reg);
        cpb0 = (cpb_reg <= 5'd1) ? 5'd1 : cpb_reg;
        cpb  = (cpb0 > nc) ? nc : cpb0;
        a1s  = signed'({4'd0, a1_reg});
        a2s  = signed'({{3{a2_reg[4]}}, a2_reg});
        nas  = signed'({3'd0, na});
        tri_n = (a1_reg == 4'd0) ? 8'd0 :
                8'((8'(a1_reg) * 8'(a1_reg - 4'd1)) >> 1);
        pol_bad  = 32'(pol_reg) >= POLS;
        two_rows = (row_mode_reg == MODE_AVG);
        row1     = ROWC_W'(a2_reg[3:0]);
        ant_bad  = 1'b0;
        row0     = '0;
        unique case (row_mode_reg)
            MODE_ALL: row0 = '0;
            MODE_ANT:
            begin
                row0    = ROWC_W'(a1_reg);
                ant_bad = a1s >= nas;
            end
            MODE_BASE:
            begin
                row0    = ROWC_W'(na) * ROWC_W'(a1_reg) - ROWC_W'(tri_n)
                          + ROWC_W'(a2_reg[3:0]) - ROWC_W'(a1_reg);
                ant_bad = a1s >= nas || a2s < a1s || a2s >= nas;
            end
            MODE_AVG:
            begin
                row0    = ROWC_W'(a1_reg);
                ant_bad = a1s >= nas || a2s < 8'sd0 || a2s >= nas;
            end
            default: row0 = '0;
        endcase
        arow = cmd.row_sel ? row1 : row0;
    end

    assign sts.func       = func_reg;
    assign sts.two_rows   = two_rows;
    assign sts.acc_reject = ({1'b0, ch_reg} >= nc) || pol_bad || ant_bad
                            || 32'(row0) >= ROWS || (two_rows && 32'(row1) >= ROWS);
    assign sts.rd_reject  = 32'(rrow_reg) >= ROWS || pol_bad || 32'(ch_reg) >= CHANS;

    // output bin search: repeated add of the bin width
    logic [5:0] bin_b_reg;
    logic [3:0] bin_q_reg;
    logic [5:0] bin_end;

    assign bin_end      = bin_b_reg + 6'(cpb);
    assign sts.bin_more = bin_end <= 6'(ch_reg);
    assign sts.bin_drop = bin_end > 6'(nc);

    always_ff @(posedge clk)
    begin
        if (cmd.bin_init)
        begin
            bin_b_reg <= '0;
            bin_q_reg <= '0;
        end
        else if (cmd.bin_step)
        begin
            bin_b_reg <= bin_end;
            bin_q_reg <= bin_q_reg + 4'd1;
        end
    end

    // presence bits
    logic [ROWS-1:0]   row_seen_reg;
    logic [ROWC_W-1:0] rrow12;

    assign rrow12 = ROWC_W'(rrow_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_seen_reg <= '0;
        end
        else if (cmd.clr_start)
        begin
            row_seen_reg <= '0;
        end
        else if (cmd.seen_mark)
        begin
            row_seen_reg[row0[ROW_W-1:0]] <= 1'b1;
            if (two_rows)
            begin
                row_seen_reg[row1[ROW_W-1:0]] <= 1'b1;
            end
        end
    end

    // clearing sweep
    logic [CA_W-1:0] clr_addr_reg;

    assign sts.clr_last = 32'(clr_addr_reg) == CELLS - 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_start)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= sts.clr_last ? '0 : clr_addr_reg + CA_W'(1);
        end
    end

    // cell memory
    logic [CA_W-1:0]   acell, rcell, raddr, waddr;
    logic [CELL_W-1:0] rdata, wdata;
    fwca_cell_t        cell_reg, upd, clr_val;
    logic              we, skip;

    assign acell = CA_W'((32'(arow) * POLS + 32'(pol_reg)) * CHANS + 32'(bin_q_reg));
    assign rcell = CA_W'((32'(rrow_reg) * POLS + 32'(pol_reg)) * CHANS + 32'(ch_reg));
    assign raddr = cmd.rd_read ? rcell : acell;

    always_comb
    begin
        clr_val      = '0;
        clr_val.flag = 1'b1;
    end

    assign waddr = cmd.clr_step ? clr_addr_reg : acell;
    assign wdata = cmd.clr_step ? CELL_W'(clr_val) : CELL_W'(upd);
    assign we    = cmd.clr_step || (cmd.wr_en && !skip);

    fwca_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // products, one register stage ahead of the saturating adds
    logic [31:0]        w_eff;
    logic signed [63:0] prod_reg [4];

    assign w_eff = (w_reg == 32'd0) ? 32'd1 : w_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            cell_reg <= fwca_cell_t'(rdata);
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= 64'(signed'(val_reg[k]) * signed'({1'b0, w_eff}));
            end
        end
    end

    logic              reset_cell;
    logic [64:0]       s65 [4];
    logic [40:0]       ws41;
    fwca_cell_t        base;

    always_comb
    begin
        // an unflagged sample restarts a cell that has only seen flagged ones
        reset_cell = !flg_reg && cell_reg.flag;
        skip       = flg_reg && !cell_reg.flag;
        base       = reset_cell ? fwca_cell_t'('0) : cell_reg;
        upd.flag   = cell_reg.flag && flg_reg;
        ws41       = {1'b0, base.wsum} + 41'(w_eff);
        upd.wsum   = ws41[40] ? {40{1'b1}} : ws41[39:0];
        for (int k = 0; k < 4; k++)
        begin
            s65[k] = {base.sum[k][63], base.sum[k]} + {prod_reg[k][63], prod_reg[k]};
            if (s65[k][64] != s65[k][63])
            begin
                upd.sum[k] = s65[k][64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
            else
            begin
                upd.sum[k] = s65[k][63:0];
            end
        end
    end

    // restoring divider, one quotient bit a cycle, four quantities in turn
    logic [1:0]  div_k_reg;
    logic [5:0]  div_cnt_reg;
    logic [63:0] dvd_reg, quo_reg, quo_n, sel_sum, sel_mag;
    logic [39:0] rem_reg, rem_n;
    logic [40:0] rem_sh;
    logic        neg_reg, ge;
    logic [31:0] avg_reg [4];
    logic [31:0] avg_n;
    logic [1:0]  k_load;

    assign k_load  = cmd.div_init ? 2'd0 : div_k_reg + 2'd1;
    assign sel_sum = cell_reg.sum[k_load];
    assign sel_mag = sel_sum[63] ? (~sel_sum + 64'd1) : sel_sum;
    assign rem_sh  = {rem_reg, dvd_reg[63]};
    assign ge      = rem_sh >= {1'b0, cell_reg.wsum};
    assign rem_n   = ge ? 40'(rem_sh - {1'b0, cell_reg.wsum}) : rem_sh[39:0];
    assign quo_n   = {quo_reg[62:0], ge};
    assign sts.div_last = (div_cnt_reg == 6'd63) && (div_k_reg == 2'd3);

    always_comb
    begin
        if (cell_reg.wsum == 40'd0)
        begin
            avg_n = '0;
        end
        else if (neg_reg)
        begin
            avg_n = (quo_n > 64'h8000_0000) ? 32'h8000_0000 : 32'(~quo_n + 64'd1);
        end
        else
        begin
            avg_n = (quo_n > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_n[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init || (cmd.div_step && div_cnt_reg == 6'd63))
        begin
            if (cmd.div_step)
            begin
                avg_reg[div_k_reg] <= avg_n;
            end
            div_k_reg   <= k_load;
            div_cnt_reg <= '0;
            dvd_reg     <= sel_mag;
            neg_reg     <= sel_sum[63];
            rem_reg     <= '0;
            quo_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 6'd1;
            dvd_reg     <= {dvd_reg[62:0], 1'b0};
            rem_reg     <= rem_n;
            quo_reg     <= quo_n;
        end
    end

    // output register
    logic                 m_valid_reg;
    logic [OUT_D_W-1:0]   m_data_reg;
    logic [OUT_U_W-1:0]   m_user_reg;

    assign sts.out_hold = m_valid_reg && !m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;
    assign m_tuser      = m_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            m_data_reg <= '0;
            m_user_reg <= '0;
            unique case (cmd.res_kind)
                RES_ERR: m_user_reg <= 3'b001;
                RES_READ:
                begin
                    m_user_reg <= {cell_reg.flag, row_seen_reg[rrow12[ROW_W-1:0]], 1'b0};
                    m_data_reg <= {cell_reg.wsum, avg_reg[3], avg_reg[2],
                                   avg_reg[1], avg_reg[0]};
                end
                default: m_user_reg <= '0;
            endcase
        end
    end
endmodule

// ----- rtl/flagged_weighted_cell_averager.sv -----
// Top level of the flagged weighted cell averager.
// After reset a clearing pass writes all ROWS*POLS*CHANS cells with s_tready
// low; a clear item runs the same pass.
// Accumulate: decode, the output-bin steps, then a read, multiply and write
// for each row updated (two rows in antenna averaging).
// Read: the bit-serial divider works out the four means in turn.
// One item at a time; the result register lets the next item in while it waits.
module flagged_weighted_cell_averager #(
    parameter int MAX_ANTS = fwca_pkg::MAX_ANTS_DEF,
    parameter int POLS     = fwca_pkg::POLS_DEF,
    parameter int CHANS    = fwca_pkg::CHANS_DEF,
    parameter int ROWS     = fwca_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [4:0]                    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // ant_first, ant_second, read_row, pol, chan, weight, value_re, value_im,
    // value_err, value_snr, zero pad
    input  logic [fwca_pkg::IN_D_W-1:0]   s_tdata,
    // func, flagged
    input  logic [fwca_pkg::IN_U_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // avg_re, avg_im, avg_err, avg_snr, weight_sum
    output logic [fwca_pkg::OUT_D_W-1:0]  m_tdata,
    // status, row_present, cell_flagged
    output logic [fwca_pkg::OUT_U_W-1:0]  m_tuser
);
    import fwca_pkg::*;

    fwca_cmd_t cmd;
    fwca_sts_t sts;

    assign s_tready = cmd.in_ready;

    fwca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    fwca_dp #(
        .MAX_ANTS (MAX_ANTS),
        .POLS     (POLS),
        .CHANS    (CHANS),
        .ROWS     (ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule

// ----- rtl/fwca_checker.sv -----
// Port-level checks of the averager, bound to the top level.
module fwca_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata,
    input logic [2:0]   m_tuser
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a rejected item carries nothing but its status
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && m_tuser[2:1] == 2'b00)
        else $error("rejected item has non-zero fields");

    // an unflagged cell has taken at least one weight LSB
    a_unflagged_weight: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] && m_tuser[1] && !m_tuser[2] |-> m_tdata[167:128] != 40'd0)
        else $error("unflagged cell with zero weight");

    // weight in a cell implies its row was marked present
    a_weight_present: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[167:128] != 40'd0 |-> m_tuser[1])
        else $error("weighted cell in absent row");
endmodule

bind flagged_weighted_cell_averager fwca_checker u_fwca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for the flagged weighted cell averager: directed and random items.
`timescale 1ns / 1ps

module tb_top;
    import fwca_pkg::*;

    localparam int NCELL = ROWS_DEF * POLS_DEF * CHANS_DEF;
    localparam longint WMAX = 64'hFF_FFFF_FFFF;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  ant_first;
        logic [4:0]  ant_second;
        logic [7:0]  read_row;
        logic        pol;
        logic [3:0]  chan;
        logic        flagged;
        logic [31:0] weight;
        logic [31:0] value_re;
        logic [31:0] value_im;
        logic [31:0] value_err;
        logic [31:0] value_snr;
    } sample_t;

    typedef struct packed {
        logic        status;
        logic        row_present;
        logic        cell_flagged;
        logic [31:0] avg_re;
        logic [31:0] avg_im;
        logic [31:0] avg_err;
        logic [31:0] avg_snr;
        logic [39:0] weight_sum;
    } cell_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [4:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_D_W-1:0] s_tdata = '0;
    logic [IN_U_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_D_W-1:0] m_tdata;
    logic [OUT_U_W-1:0] m_tuser;

    // model state
    bit          cf_flag [NCELL];
    longint      cf_sum [4][NCELL];
    longint      cf_wsum [NCELL];
    bit          cf_seen [ROWS_DEF];
    logic [1:0]  cf_mode;
    logic [4:0]  cf_ants, cf_chans, cf_cpb;

    cell_result_t results_due[$];
    int  errors = 0;
    longint cycles = 0;
    bit  hold_rx = 1'b0;

    flagged_weighted_cell_averager u_top (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic longint sat_sum(longint a, longint b);
        longint r;
        r = a + b;
        if (b > 0 && r < a) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (b < 0 && r > a) return 64'sh8000_0000_0000_0000;
        return r;
    endfunction

    function automatic logic [31:0] mean_of(longint s, longint w);
        logic [63:0] mag, q;
        if (w == 0) return '0;
        mag = (s < 0) ? 64'(-s) : 64'(s);
        q = mag / 64'(w);
        if (s < 0) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function automatic void wipe_cells();
        for (int c = 0; c < NCELL; c++)
        begin
            cf_flag[c] = 1'b1;
            cf_wsum[c] = 0;
            for (int k = 0; k < 4; k++) cf_sum[k][c] = 0;
        end
        for (int r = 0; r < ROWS_DEF; r++) cf_seen[r] = 1'b0;
    endfunction

    function automatic void add_to_cell(int c, sample_t s, longint w);
        longint v [4];
        v[0] = longint'(signed'(s.value_re));
        v[1] = longint'(signed'(s.value_im));
        v[2] = longint'(signed'(s.value_err));
        v[3] = longint'(signed'(s.value_snr));
        if (!s.flagged)
        begin
            if (cf_flag[c])
            begin
                cf_flag[c] = 1'b0;
                cf_wsum[c] = 0;
                for (int k = 0; k < 4; k++) cf_sum[k][c] = 0;
            end
        end
        else if (!cf_flag[c])
            return;
        cf_wsum[c] = (cf_wsum[c] + w > WMAX) ? WMAX : cf_wsum[c] + w;
        for (int k = 0; k < 4; k++) cf_sum[k][c] = sat_sum(cf_sum[k][c], v[k] * w);
    endfunction

    function automatic bit accumulate_sample(sample_t s);
        int na, nc, cpb, a1, a2, nrows, ochan;
        int rows [2];
        longint w;
        na = (cf_ants < 1) ? 1 : (cf_ants > 16 ? 16 : cf_ants);
        nc = (cf_chans < 1) ? 1 : (cf_chans > 16 ? 16 : cf_chans);
        cpb = (cf_cpb <= 1) ? 1 : cf_cpb;
        if (cpb > nc) cpb = nc;
        a1 = s.ant_first;
        a2 = int'(signed'(s.ant_second));
        nrows = 1;
        if (s.chan >= nc) return 1'b1;
        if (cf_mode == MODE_ALL)
            rows[0] = 0;
        else
        begin
            if (a1 >= na) return 1'b1;
            if (cf_mode == MODE_ANT)
                rows[0] = a1;
            else if (cf_mode == MODE_BASE)
            begin
                if (a2 < a1 || a2 >= na) return 1'b1;
                rows[0] = na * a1 - (a1 * (a1 > 0 ? a1 - 1 : 0)) / 2 + a2 - a1;
            end
            else
            begin
                if (a2 < 0 || a2 >= na) return 1'b1;
                rows[0] = a1;
                rows[1] = a2;
                nrows = 2;
            end
        end
        for (int i = 0; i < nrows; i++)
            if (rows[i] >= ROWS_DEF) return 1'b1;
        for (int i = 0; i < nrows; i++) cf_seen[rows[i]] = 1'b1;
        ochan = s.chan / cpb;
        if (ochan >= nc / cpb) return 1'b0;   // incomplete bin dropped
        w = (s.weight == 0) ? 1 : longint'(s.weight);
        for (int i = 0; i < nrows; i++)
            add_to_cell((rows[i] * POLS_DEF + s.pol) * CHANS_DEF + ochan, s, w);
        return 1'b0;
    endfunction

    function automatic cell_result_t predict_cell(sample_t s);
        cell_result_t r;
        int c;
        r = '0;
        case (s.func)
            FUNC_CLR: wipe_cells();
            FUNC_ACC: r.status = accumulate_sample(s);
            FUNC_RD:
            begin
                if (s.read_row >= ROWS_DEF)
                    r.status = 1'b1;
                else
                begin
                    c = (s.read_row * POLS_DEF + s.pol) * CHANS_DEF + s.chan;
                    r.row_present = cf_seen[s.read_row];
                    r.cell_flagged = cf_flag[c];
                    r.avg_re = mean_of(cf_sum[0][c], cf_wsum[c]);
                    r.avg_im = mean_of(cf_sum[1][c], cf_wsum[c]);
                    r.avg_err = mean_of(cf_sum[2][c], cf_wsum[c]);
                    r.avg_snr = mean_of(cf_sum[3][c], cf_wsum[c]);
                    r.weight_sum = cf_wsum[c][39:0];
                end
            end
            default: r.status = 1'b1;
        endcase
        return r;
    endfunction

    // s_tvalid drops only when a gap follows or the bench drains, so back-to-back items keep it high
    task automatic gap(int cap_long);
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, cap_long) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_item(sample_t s);
        results_due.insert(results_due.size(), predict_cell(s));
        s_tdata <= {2'b0, s.value_snr, s.value_err, s.value_im, s.value_re, s.weight,
                    s.chan, s.pol, s.read_row, s.ant_second, s.ant_first};
        s_tuser <= {s.flagged, s.func};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic paced_send(sample_t s, bit pace);
        send_item(s);
        if (pace) gap(40);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ROW_MODE: cf_mode = val[1:0];
            REG_NUM_ANTS: cf_ants = val;
            REG_NUM_CHANS: cf_chans = val;
            default: cf_cpb = val;
        endcase
    endtask

    task automatic set_config(logic [1:0] m, logic [4:0] na, logic [4:0] nc, logic [4:0] cpb);
        write_reg(REG_ROW_MODE, {3'd0, m});
        write_reg(REG_NUM_ANTS, na);
        write_reg(REG_NUM_CHANS, nc);
        write_reg(REG_CPB, cpb);
    endtask

    function automatic sample_t rand_sample();
        sample_t s;
        s.func = FUNC_ACC;
        s.ant_first = 4'($urandom_range(0, 15));
        s.ant_second = ($urandom_range(0, 9) == 0) ? 5'h1F : 5'($urandom_range(0, 15));
        s.read_row = 8'($urandom_range(0, 15));
        s.pol = 1'($urandom_range(0, 1));
        s.chan = 4'($urandom_range(0, 15));
        s.flagged = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 5))
            0: s.weight = 32'hFFFF_FFFF;
            1: s.weight = 32'd0;
            default: s.weight = $urandom_range(0, 32'h0400_0000);
        endcase
        s.value_re = $urandom();
        s.value_im = $urandom();
        s.value_err = ($urandom_range(0, 1)) ? $urandom() : $urandom_range(0, 65536);
        s.value_snr = $urandom();
        return s;
    endfunction

    function automatic sample_t read_of(int row, bit pol, int ch);
        sample_t s;
        s = rand_sample();
        s.func = FUNC_RD;
        s.read_row = 8'(row);
        s.pol = pol;
        s.chan = 4'(ch);
        return s;
    endfunction

    task automatic test_directed();
        sample_t s;
        set_config(MODE_ANT, 5'd16, 5'd16, 5'd1);
        s = rand_sample();
        s.ant_first = 4'hF; s.chan = 4'hF; s.pol = 1'b1; s.flagged = 1'b0;
        s.weight = 32'hFFFF_FFFF; s.value_re = 32'h7FFF_FFFF; s.value_im = 32'h8000_0000;
        s.value_err = 32'hFFFF_FFFF; s.value_snr = 32'h0;
        paced_send(s, 0);
        paced_send(s, 0);                       // saturation
        paced_send(read_of(15, 1, 15), 0);
        s.flagged = 1'b1; s.ant_first = 4'd3; s.chan = 4'd2; s.weight = 32'd0;
        paced_send(s, 0);                       // flagged into fresh cell
        paced_send(read_of(3, 1, 2), 0);
        s.flagged = 1'b0;
        paced_send(s, 0);                       // unflagged resets it
        s.flagged = 1'b1;
        paced_send(s, 0);                       // flagged ignored now
        paced_send(read_of(3, 1, 2), 0);
        paced_send(read_of(135, 0, 0), 0);
        paced_send(read_of(136, 0, 0), 0);      // row out of range
        paced_send(read_of(255, 1, 15), 0);
        s.func = 2'd3;
        paced_send(s, 0);                       // unused code
        s = rand_sample(); s.chan = 4'd15;
        drain();
        write_reg(REG_NUM_CHANS, 5'd5);
        paced_send(s, 0);                       // channel out of range
        s.chan = 4'd4; s.ant_first = 4'd0;
        paced_send(s, 0);
        drain();
        write_reg(REG_CPB, 5'd2);
        paced_send(s, 0);                       // incomplete bin
        paced_send(read_of(0, s.pol, 2), 0);
        s = rand_sample(); s.func = FUNC_CLR;
        paced_send(s, 0);
        paced_send(read_of(15, 1, 15), 0);
        drain();
    endtask

    task automatic test_modes();
        sample_t s;
        logic [4:0] cfgs [6][4] = '{'{5'(MODE_ALL), 5'd1, 5'd1, 5'd0},
            '{5'(MODE_ANT), 5'd1, 5'd16, 5'd16},
            '{5'(MODE_BASE), 5'd16, 5'd16, 5'd4}, '{5'(MODE_AVG), 5'd16, 5'd16, 5'd1},
            '{5'(MODE_BASE), 5'd5, 5'd7, 5'd3},
            '{5'(MODE_AVG), 5'd0, 5'd31, 5'd31}};
        for (int p = 0; p < 6; p++)
        begin
            set_config(cfgs[p][0][1:0], cfgs[p][1], cfgs[p][2], cfgs[p][3]);
            for (int i = 0; i < 120; i++)
            begin
                s = rand_sample();
                if ($urandom_range(0, 7) != 0)
                begin
                    // keep most antennas valid for this mode
                    s.ant_first = 4'($urandom_range(0, 4));
                    s.ant_second = 5'(s.ant_first + $urandom_range(0, 3));
                    s.chan = 4'($urandom_range(0, 6));
                end
                if ($urandom_range(0, 5) == 0)
                    s = read_of($urandom_range(0, 20), 1'($urandom_range(0, 1)),
                                $urandom_range(0, 15));
                else if ($urandom_range(0, 150) == 0)
                    s.func = FUNC_CLR;
                else if ($urandom_range(0, 100) == 0)
                    s.func = 2'd3;
                paced_send(s, $urandom_range(0, 2) != 0);
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        sample_t s;
        set_config(MODE_AVG, 5'd8, 5'd8, 5'd2);
        hold_rx = 1'b1;
        fork
        begin
            repeat (400) @(posedge clk);
            hold_rx = 1'b0;
        end
        begin
            for (int i = 0; i < 40; i++)
            begin
                s = rand_sample();
                s.ant_first = 4'($urandom_range(0, 7));
                s.ant_second = 5'($urandom_range(0, 7));
                s.chan = 4'($urandom_range(0, 7));
                if (i % 8 == 7) s = read_of(s.ant_first, s.pol, 1);
                paced_send(s, 0);
            end
        end
        join
        drain();
    endtask

    always @(posedge clk)
    begin
        cell_result_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tuser[0], m_tuser[1], m_tuser[2], m_tdata[31:0], m_tdata[63:32],
                   m_tdata[95:64], m_tdata[127:96], m_tdata[167:128]};
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end
            else
            begin
                want = results_due.pop_front();
                if (got.status !== want.status || got.row_present !== want.row_present ||
                    got.cell_flagged !== want.cell_flagged || got.avg_re !== want.avg_re ||
                    got.avg_im !== want.avg_im || got.avg_err !== want.avg_err ||
                    got.avg_snr !== want.avg_snr || got.weight_sum !== want.weight_sum)
                begin
                    $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_rx)
                m_tready <= 1'b0;
            else if ($urandom_range(0, 5) == 0)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        cf_mode = MODE_ANT; cf_ants = 5'd16; cf_chans = 5'd16; cf_cpb = 5'd1;
        wipe_cells();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_modes();
        test_backpressure();
        drain();
        if (errors == 0 && results_due.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
